>>> rtl/ogdd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ogdd_pkg
// Shared types and constants for the occupancy grid disc dilation block.
// ----------------------------------------------------------------------------
package ogdd_pkg;

    localparam int CELL_W  = 8;   // occupancy cell width
    localparam int POS_W   = 8;   // col / row field width
    localparam int DIM_W   = 9;   // map_width / map_height register width
    localparam int RAD_W   = 5;   // dilate_radius register width
    localparam int COORD_W = 10;  // signed neighbour coordinate
    localparam int OFS_W   = 6;   // signed disc offset
    localparam int RSQ_W   = 10;  // radius squared
    localparam int SQ_W    = 12;  // offset square sum
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 9;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OCC_THRESH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FILL_VALUE = 3'd4;

    // Register reset values
    localparam logic [DIM_W-1:0]  RST_MAP_WIDTH  = 9'd256;
    localparam logic [DIM_W-1:0]  RST_MAP_HEIGHT = 9'd256;
    localparam logic [RAD_W-1:0]  RST_RADIUS     = 5'd0;
    localparam logic [CELL_W-1:0] RST_OCC_THRESH = 8'd50;
    localparam logic [CELL_W-1:0] RST_FILL_VALUE = 8'd90;

    // Action codes
    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    typedef enum logic [1:0] {
        RES_NONE,
        RES_ERROR,
        RES_ECHO,
        RES_DILATE
    } t_res_sel;

    typedef struct packed {
        logic     start;      // latch input item, reset scan
        logic     mem_wr;     // store cell at addressed position
        logic     rd_scan;    // read current disc point if valid
        logic     rd_center;  // read addressed cell
        logic     step;       // advance disc offsets
        t_res_sel res_sel;    // result register load
        logic     push;       // move result to output register
    } t_cmd;

    typedef struct packed {
        logic pos_err;
        logic is_query;
        logic rad_zero;
        logic scan_last;
        logic out_free;
    } t_sts;

endpackage

>>> rtl/occupancy_grid_disc_dilation.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// occupancy_grid_disc_dilation
// Occupancy grid store with disc-shaped dilation on query.
// ----------------------------------------------------------------------------
// Usage notes:
//  - Input stream (s_axis): one transaction per item. tuser = action (0 store
//    a cell, 1 query the dilated cell); tdata = col, row, cell_in.
//  - Output stream (m_axis): exactly one transaction per input item, in
//    order. tdata = cell_out, tuser = position_error.
//  - Out-of-map col/row: position_error set, cell_out zero, nothing stored.
//  - Config port: single-cycle writes on i_cfg_wr_en, index 0..4 =
//    map_width, map_height, dilate_radius, occupied_threshold, fill_value.
//    Write only while the block is idle.
//  - The disc scan is bound by the single grid memory port: it reads one
//    neighbour cell per cycle.
//  - One item in flight: s_axis_tready is high only while the sequencer is
//    idle, so an item is taken only once the last result has been moved
//    into the output register. A finished result waits in the output
//    register, so a stalled receiver does not stop the next item from being
//    taken and worked on.
//  - Reset (sync, active low) restores register defaults and clears control
//    state. Grid contents are not cleared: an unwritten cell reads as junk.
// ----------------------------------------------------------------------------
module occupancy_grid_disc_dilation
    import ogdd_pkg::*;
#(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int MAX_RADIUS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    // input items
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [23:0]           s_axis_tdata,  // col[7:0], row[15:8], cell_in[23:16]
    input  logic                  s_axis_tuser,  // action[0]
    // results
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [7:0]            m_axis_tdata,  // cell_out[7:0]
    output logic                  m_axis_tuser   // position_error[0]
);

    t_cmd cmd;
    t_sts sts;

    // sequencer: owns the handshake on the input side
    ogdd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // datapath: grid memory, scan, result and output registers
    ogdd_dp #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .MAX_RADIUS (MAX_RADIUS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_action    (s_axis_tuser),
        .i_col       (s_axis_tdata[7:0]),
        .i_row       (s_axis_tdata[15:8]),
        .i_cell_in   (s_axis_tdata[23:16]),
        .i_out_ready (m_axis_tready),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (m_axis_tvalid),
        .o_cell_out  (m_axis_tdata),
        .o_pos_err   (m_axis_tuser)
    );

endmodule

>>> rtl/ogdd_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ogdd_dp
// Datapath: configuration registers, grid memory, disc scan counters,
// hit detection and the output register.
// ----------------------------------------------------------------------------
module ogdd_dp
    import ogdd_pkg::*;
#(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int MAX_RADIUS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  i_action,
    input  logic [POS_W-1:0]      i_col,
    input  logic [POS_W-1:0]      i_row,
    input  logic [CELL_W-1:0]     i_cell_in,
    input  logic                  i_out_ready,
    input  t_cmd                  i_cmd,
    output t_sts                  o_sts,
    output logic                  o_out_valid,
    output logic [CELL_W-1:0]     o_cell_out,
    output logic                  o_pos_err
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int WLIM  = (MAX_WIDTH  > 511) ? 511 : MAX_WIDTH;
    localparam int HLIM  = (MAX_HEIGHT > 511) ? 511 : MAX_HEIGHT;
    localparam int RLIM  = (MAX_RADIUS > 31)  ? 31  : MAX_RADIUS;

    // configuration
    logic [DIM_W-1:0]  r_map_width, r_map_height;
    logic [RAD_W-1:0]  r_radius;
    logic [CELL_W-1:0] r_thresh, r_fill;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_width  <= RST_MAP_WIDTH;
            r_map_height <= RST_MAP_HEIGHT;
            r_radius     <= RST_RADIUS;
            r_thresh     <= RST_OCC_THRESH;
            r_fill       <= RST_FILL_VALUE;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_MAP_WIDTH:  r_map_width  <= i_cfg_wdata;
                CFG_MAP_HEIGHT: r_map_height <= i_cfg_wdata;
                CFG_RADIUS:     r_radius     <= i_cfg_wdata[RAD_W-1:0];
                CFG_OCC_THRESH: r_thresh     <= i_cfg_wdata[CELL_W-1:0];
                CFG_FILL_VALUE: r_fill       <= i_cfg_wdata[CELL_W-1:0];
                default: ;
            endcase
        end
    end

    // effective map size and radius, clipped to the storage
    logic [DIM_W-1:0] w_eff, h_eff;
    logic [RAD_W-1:0] rad_eff;
    assign w_eff   = (r_map_width  > DIM_W'(WLIM)) ? DIM_W'(WLIM) : r_map_width;
    assign h_eff   = (r_map_height > DIM_W'(HLIM)) ? DIM_W'(HLIM) : r_map_height;
    assign rad_eff = (r_radius > RAD_W'(RLIM)) ? RAD_W'(RLIM) : r_radius;

    // latched item
    logic              r_act;
    logic [POS_W-1:0]  r_col, r_row;
    logic [CELL_W-1:0] r_cell;
    logic [RAD_W-1:0]  r_rad;
    logic [RSQ_W-1:0]  r_rsq;
    logic signed [OFS_W-1:0] r_dx, r_dy;

    logic signed [OFS_W-1:0] rad_m1;
    assign rad_m1 = $signed({1'b0, r_rad}) - OFS_W'(1);

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_act  <= i_action;
            r_col  <= i_col;
            r_row  <= i_row;
            r_cell <= i_cell_in;
            r_rad  <= rad_eff;
            r_rsq  <= RSQ_W'(rad_eff * rad_eff);
            r_dx   <= -$signed({1'b0, rad_eff});
            r_dy   <= -$signed({1'b0, rad_eff});
        end else if (i_cmd.step) begin
            if (r_dy == rad_m1) begin
                r_dy <= -$signed({1'b0, r_rad});
                r_dx <= r_dx + OFS_W'(1);
            end else begin
                r_dy <= r_dy + OFS_W'(1);
            end
        end
    end

    // current disc point
    logic [SQ_W-1:0]           dx_sq, dy_sq, sq_sum;
    logic signed [COORD_W-1:0] sc, sr, w_s, h_s;
    logic                      in_disc, in_map, pt_ok;

    assign dx_sq   = SQ_W'(r_dx * r_dx);
    assign dy_sq   = SQ_W'(r_dy * r_dy);
    assign sq_sum  = dx_sq + dy_sq;
    assign in_disc = sq_sum < SQ_W'(r_rsq);
    assign sc      = $signed(COORD_W'(r_col)) - COORD_W'(r_dx);
    assign sr      = $signed(COORD_W'(r_row)) - COORD_W'(r_dy);
    assign w_s     = $signed(COORD_W'(w_eff));
    assign h_s     = $signed(COORD_W'(h_eff));
    assign in_map  = (sc >= 0) && (sc < w_s) && (sr >= 0) && (sr < h_s);
    assign pt_ok   = in_disc && in_map;

    // grid memory, one port
    logic [DIM_W-1:0]  a_col, a_row;
    logic [AW-1:0]     addr;
    logic              rd_en;
    logic [CELL_W-1:0] r_mem [DEPTH];
    logic [CELL_W-1:0] r_rd_data;
    logic              r_chk, r_hit;

    assign a_col = i_cmd.rd_scan ? sc[DIM_W-1:0] : DIM_W'(r_col);
    assign a_row = i_cmd.rd_scan ? sr[DIM_W-1:0] : DIM_W'(r_row);
    assign addr  = AW'(a_row) * AW'(MAX_WIDTH) + AW'(a_col);
    assign rd_en = (i_cmd.rd_scan && pt_ok) || i_cmd.rd_center;

    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_wr) begin
            r_mem[addr] <= r_cell;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[addr];
        end
    end

    logic occupied;
    assign occupied = $signed(r_rd_data) >= $signed(r_thresh);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chk <= 1'b0;
            r_hit <= 1'b0;
        end else begin
            r_chk <= i_cmd.rd_scan && pt_ok;
            if (i_cmd.start) begin
                r_hit <= 1'b0;
            end else if (r_chk && occupied) begin
                r_hit <= 1'b1;
            end
        end
    end

    // result and output register
    logic [CELL_W-1:0] r_res;
    logic              r_res_err;
    logic              r_out_valid;
    logic [CELL_W-1:0] r_out_data;
    logic              r_out_perr;

    always_ff @(posedge i_clk) begin
        case (i_cmd.res_sel)
            RES_ERROR: begin
                r_res     <= '0;
                r_res_err <= 1'b1;
            end
            RES_ECHO: begin
                r_res     <= r_cell;
                r_res_err <= 1'b0;
            end
            RES_DILATE: begin
                r_res     <= r_hit ? r_fill : r_rd_data;
                r_res_err <= 1'b0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.push) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_out_data <= r_res;
            r_out_perr <= r_res_err;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_cell_out  = r_out_data;
    assign o_pos_err   = r_out_perr;

    assign o_sts.pos_err   = ({1'b0, r_col} >= w_eff) || ({1'b0, r_row} >= h_eff);
    assign o_sts.is_query  = (r_act == ACT_QUERY);
    assign o_sts.rad_zero  = (r_rad == '0);
    assign o_sts.scan_last = (r_dx == rad_m1) && (r_dy == rad_m1);
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

    // an out-of-map result carries a zero cell
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_perr |-> r_out_data == '0)
        else $error("position error with non-zero cell");

    // scan offsets stay inside the square window
    a_scan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rd_scan |-> (r_dx >= -$signed({1'b0, r_rad})) && (r_dx <= rad_m1)
                          && (r_dy >= -$signed({1'b0, r_rad})) && (r_dy <= rad_m1))
        else $error("disc offset outside window");

endmodule

>>> rtl/ogdd_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ogdd_ctrl
// Sequencer: accepts an item, stores it or runs the disc scan, loads the result.
// ----------------------------------------------------------------------------
module ogdd_ctrl
    import ogdd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_CENTER,
        S_LAST,
        S_DONE
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state       = r_state;
        o_cmd         = '0;
        o_cmd.res_sel = RES_NONE;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    n_state     = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_sts.pos_err) begin
                    o_cmd.res_sel = RES_ERROR;
                    n_state       = S_DONE;
                end else if (!i_sts.is_query) begin
                    o_cmd.mem_wr  = 1'b1;
                    o_cmd.res_sel = RES_ECHO;
                    n_state       = S_DONE;
                end else if (i_sts.rad_zero) begin
                    n_state = S_CENTER;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.rd_scan = 1'b1;
                o_cmd.step    = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = S_CENTER;
                end
            end
            S_CENTER: begin
                o_cmd.rd_center = 1'b1;
                n_state         = S_LAST;
            end
            S_LAST: begin
                o_cmd.res_sel = RES_DILATE;
                n_state       = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.push = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    a_push_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.push |-> i_sts.out_free)
        else $error("result pushed onto a full output register");

    a_no_scan_r0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SCAN |-> !i_sts.rad_zero)
        else $error("scan with zero radius");

    a_start_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.start |=> r_state == S_CHECK && !o_in_ready)
        else $error("item accepted but not taken up");

endmodule

>>> tb/tb_occupancy_grid_disc_dilation.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_occupancy_grid_disc_dilation
// Self-checking bench for the occupancy grid with disc dilation.
// A short directed run covers the map corners, value extremes, out-of-map
// positions, zero and clipped map sizes, and zero and clipped radii. It is
// followed by randomised phases, each with its own register set. Cell reads
// are predicted by a behavioural copy of the grid. Every cell that a query
// can touch is written first. Both streams idle at random, and the result
// side holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb_occupancy_grid_disc_dilation;
    import ogdd_pkg::*;

    localparam int MAP_MAX_W   = 256;
    localparam int MAP_MAX_H   = 256;
    localparam int RAD_MAX     = 16;
    localparam int MAP_CELLS   = MAP_MAX_W * MAP_MAX_H;
    localparam int PHASE_ITEMS = 40;      // random transactions per random phase
    localparam int RAND_PHASES = 5;
    localparam int HOLD_AFTER  = 60;      // results before the long sink hold-off
    localparam int LONG_HOLD   = 300;     // cycles of that hold-off
    localparam int SETTLE      = 8;       // quiet cycles before a register write
    localparam int DRAIN       = 4 * RAD_MAX * RAD_MAX + 5 + 20;

    // one grid operation as it travels on the input stream
    typedef struct packed {
        logic                     action;
        logic [POS_W-1:0]         col;
        logic [POS_W-1:0]         row;
        logic signed [CELL_W-1:0] cval;
    } t_grid_op;

    // one result as it travels on the output stream
    typedef struct packed {
        logic signed [CELL_W-1:0] cval;
        logic                     pos_err;
    } t_cell_result;

    // result-side stall behaviour
    typedef enum logic [1:0] {
        SINK_OPEN,
        SINK_RANDOM,
        SINK_CHOKED
    } t_sink_mode;

    // ------------------------------------------------------------------------
    // DUT connections - every input known from time zero
    // ------------------------------------------------------------------------
    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_wr_en   = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata   = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [23:0]           s_axis_tdata;  // col[7:0], row[15:8], cell_in[23:16]
    logic                  s_axis_tuser;  // action[0]
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [7:0]            m_axis_tdata;  // cell_out[7:0]
    logic                  m_axis_tuser;  // position_error[0]

    t_grid_op offered_op = '0;   // operation currently presented on s_axis

    assign s_axis_tdata = {offered_op.cval, offered_op.row, offered_op.col};
    assign s_axis_tuser = offered_op.action;

    occupancy_grid_disc_dilation i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // 2 ns period
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Behavioural grid: register copy plus cell store
    // ------------------------------------------------------------------------
    logic [DIM_W-1:0]         map_w_reg  = RST_MAP_WIDTH;
    logic [DIM_W-1:0]         map_h_reg  = RST_MAP_HEIGHT;
    logic [RAD_W-1:0]         radius_reg = RST_RADIUS;
    logic signed [CELL_W-1:0] occ_thr    = RST_OCC_THRESH;
    logic signed [CELL_W-1:0] fill_val   = RST_FILL_VALUE;

    logic signed [CELL_W-1:0] grid_cells   [0:MAP_CELLS-1];
    bit                       cell_written [0:MAP_CELLS-1];  // stimulus-side view

    t_grid_op     grid_ops_pending [$];   // filled by stimulus, drained by driver
    t_cell_result cell_results_due [$];   // predicted, oldest first

    int  ops_queued   = 0;
    int  results_seen = 0;
    int  error_count  = 0;
    bit  op_taken     = 1'b0;             // input transaction at the last rising edge

    // map size and radius after clipping to the build limits
    function automatic int map_cols();
        return (map_w_reg > MAP_MAX_W) ? MAP_MAX_W : int'(map_w_reg);
    endfunction

    function automatic int map_rows();
        return (map_h_reg > MAP_MAX_H) ? MAP_MAX_H : int'(map_h_reg);
    endfunction

    function automatic int disc_radius();
        return (radius_reg > RAD_MAX) ? RAD_MAX : int'(radius_reg);
    endfunction

    function automatic bit in_map(int c, int r);
        return c >= 0 && r >= 0 && c < map_cols() && r < map_rows();
    endfunction

    function automatic int cell_idx(int c, int r);
        return r * MAP_MAX_W + c;
    endfunction

    // Applies one operation to the grid and returns the result it must give.
    // The disc is the asymmetric window [-R, R-1] on both axes, dx^2+dy^2 < R^2,
    // with each neighbour clipped to the map on its own axis.
    function automatic t_cell_result dilate_or_store(t_grid_op op);
        t_cell_result res;
        int           c;
        int           r;
        int           rad;
        bit           hit;
        res = '0;
        c   = int'(op.col);
        r   = int'(op.row);
        if (!in_map(c, r)) begin
            res.pos_err = 1'b1;
            return res;
        end
        if (op.action == ACT_WRITE) begin
            grid_cells[cell_idx(c, r)] = op.cval;
            res.cval = op.cval;
            return res;
        end
        rad = disc_radius();
        hit = 1'b0;
        for (int dx = -rad; dx < rad; dx++) begin
            for (int dy = -rad; dy < rad; dy++) begin
                if (dx * dx + dy * dy < rad * rad && in_map(c - dx, r - dy))
                    if (grid_cells[cell_idx(c - dx, r - dy)] >= occ_thr)
                        hit = 1'b1;
            end
        end
        res.cval = hit ? fill_val : grid_cells[cell_idx(c, r)];
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Monitor: input transactions feed the prediction, output transactions
    // are checked against the oldest prediction
    // ------------------------------------------------------------------------
    task automatic report_mismatch(string what, int got, int want);
        $display("[%0t] MISMATCH %s: got %0d, expected %0d (result #%0d)",
                 $realtime, what, got, want, results_seen);
        error_count++;
    endtask

    always @(posedge i_clk) begin
        t_cell_result due;
        op_taken = i_rst_n && s_axis_tvalid && s_axis_tready;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            results_seen++;
            if (cell_results_due.size() == 0) begin
                report_mismatch("result with nothing outstanding",
                                int'($signed(m_axis_tdata)), 0);
            end else begin
                due = cell_results_due.pop_front();
                if (m_axis_tdata !== due.cval)
                    report_mismatch("cell_out", int'($signed(m_axis_tdata)),
                                    int'(due.cval));
                if (m_axis_tuser !== due.pos_err)
                    report_mismatch("position_error", int'(m_axis_tuser),
                                    int'(due.pos_err));
            end
        end
        if (op_taken)
            cell_results_due.insert(cell_results_due.size(), dilate_or_store(offered_op));
    end

    // ------------------------------------------------------------------------
    // Driver: bursts of random length separated by random gaps
    // ------------------------------------------------------------------------
    int burst_left = 1;
    int gap_left   = 0;

    always @(negedge i_clk) begin
        t_grid_op next_op;
        logic     next_valid;
        next_op    = offered_op;
        next_valid = s_axis_tvalid;
        if (!i_rst_n) begin
            next_valid = 1'b0;
        end else if (op_taken || !s_axis_tvalid) begin
            // slot is free: either idle or the last offer was taken
            next_valid = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
            end else if (grid_ops_pending.size() > 0) begin
                next_op    = grid_ops_pending.pop_front();
                next_valid = 1'b1;
                burst_left = burst_left - 1;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
                end
            end
        end
        offered_op    <= next_op;
        s_axis_tvalid <= next_valid;
    end

    // ------------------------------------------------------------------------
    // Result sink: stretches of open, random and choked readiness, plus one
    // long hold-off so the block backs up into its input
    // ------------------------------------------------------------------------
    t_sink_mode sink_mode = SINK_OPEN;
    int         mode_left = 0;
    int         hold_left = 0;
    bit         hold_done = 1'b0;

    always @(negedge i_clk) begin
        logic ready_next;
        ready_next = 1'b1;
        if (hold_left > 0) begin
            hold_left--;
            ready_next = 1'b0;
        end else if (!hold_done && results_seen >= HOLD_AFTER) begin
            hold_done  = 1'b1;
            hold_left  = LONG_HOLD - 1;
            ready_next = 1'b0;
        end else begin
            if (mode_left == 0) begin
                sink_mode = t_sink_mode'($urandom_range(0, 2));
                mode_left = $urandom_range(4, 40);
            end
            mode_left--;
            case (sink_mode)
                SINK_OPEN:   ready_next = 1'b1;
                SINK_RANDOM: ready_next = 1'($urandom_range(0, 1));
                default:     ready_next = ($urandom_range(0, 3) == 0);
            endcase
        end
        m_axis_tready <= ready_next;
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= data;
        case (idx)
            CFG_MAP_WIDTH:  map_w_reg  = data;
            CFG_MAP_HEIGHT: map_h_reg  = data;
            CFG_RADIUS:     radius_reg = data[RAD_W-1:0];
            CFG_OCC_THRESH: occ_thr    = data[CELL_W-1:0];
            CFG_FILL_VALUE: fill_val   = data[CELL_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic program_map(logic [CFG_DATA_W-1:0] w, logic [CFG_DATA_W-1:0] h,
                               logic [CFG_DATA_W-1:0] rad, logic [CFG_DATA_W-1:0] thr,
                               logic [CFG_DATA_W-1:0] fill);
        write_reg(CFG_MAP_WIDTH,  w);
        write_reg(CFG_MAP_HEIGHT, h);
        write_reg(CFG_RADIUS,     rad);
        write_reg(CFG_OCC_THRESH, thr);
        write_reg(CFG_FILL_VALUE, fill);
    endtask

    // block idle: every queued transaction has produced its result
    task automatic settle();
        do @(negedge i_clk); while (results_seen != ops_queued);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic queue_op(logic action, int c, int r, logic signed [CELL_W-1:0] v);
        t_grid_op op;
        op.action = action;
        op.col    = c[POS_W-1:0];
        op.row    = r[POS_W-1:0];
        op.cval   = v;
        grid_ops_pending.insert(grid_ops_pending.size(), op);
        ops_queued++;
        if (action == ACT_WRITE && in_map(c, r))
            cell_written[cell_idx(c, r)] = 1'b1;
    endtask

    // background value, mostly below the current threshold so discs stay sparse
    function automatic logic signed [CELL_W-1:0] quiet_cell();
        int hi;
        hi = int'(occ_thr) - 1;
        if (hi < -128 || $urandom_range(0, 7) == 0)
            return CELL_W'($urandom_range(0, 255));
        return CELL_W'(int'($urandom_range(0, hi + 128)) - 128);
    endfunction

    // a query is only issued once every cell it may read has been written
    task automatic queue_query(int c, int r);
        int rad;
        rad = disc_radius();
        if (in_map(c, r)) begin
            for (int dx = -rad; dx < rad; dx++) begin
                for (int dy = -rad; dy < rad; dy++) begin
                    if (dx * dx + dy * dy < rad * rad && in_map(c - dx, r - dy))
                        if (!cell_written[cell_idx(c - dx, r - dy)])
                            queue_op(ACT_WRITE, c - dx, r - dy, quiet_cell());
                end
            end
            if (!cell_written[cell_idx(c, r)])
                queue_op(ACT_WRITE, c, r, quiet_cell());
        end
        queue_op(ACT_QUERY, c, r, CELL_W'($urandom_range(0, 255)));
    endtask

    function automatic logic [CFG_DATA_W-1:0] pick_dim(bit tight);
        if (tight)
            return CFG_DATA_W'($urandom_range(1, 12));
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return CFG_DATA_W'($urandom_range(MAP_MAX_W + 1, 511));
            2:       return CFG_DATA_W'(MAP_MAX_W);
            default: return CFG_DATA_W'($urandom_range(1, MAP_MAX_W));
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_cell_word();
        logic [CFG_DATA_W-1:0] word;
        word = CFG_DATA_W'($urandom_range(0, 511));   // top bit is spare, toggle it anyway
        case ($urandom_range(0, 7))
            0:       word[CELL_W-1:0] = 8'h80;
            1:       word[CELL_W-1:0] = 8'h7F;
            default: ;
        endcase
        return word;
    endfunction

    function automatic int box_anchor(int span);
        case ($urandom_range(0, 3))
            0:       return 0;
            1:       return (span > 5) ? span - 5 : 0;
            default: return (span > 0) ? $urandom_range(0, span - 1) : $urandom_range(0, 255);
        endcase
    endfunction

    task automatic random_phase();
        int                    rad;
        int                    ax;
        int                    ay;
        int                    c;
        int                    r;
        int                    pick;
        logic [CFG_DATA_W-1:0] rad_word;
        pick = $urandom_range(0, 9);
        if (pick < 6)
            rad = $urandom_range(0, 6);
        else if (pick < 8)
            rad = $urandom_range(7, 15);
        else if (pick == 8)
            rad = RAD_MAX;
        else
            rad = $urandom_range(RAD_MAX + 1, 31);
        rad_word = CFG_DATA_W'($urandom_range(0, 511));
        rad_word[RAD_W-1:0] = rad[RAD_W-1:0];
        // wide discs get a small map so the pre-fill stays cheap
        program_map(pick_dim(rad >= 7), pick_dim(rad >= 7), rad_word,
                    pick_cell_word(), pick_cell_word());
        ax = box_anchor(map_cols());
        ay = box_anchor(map_rows());
        for (int n = 0; n < PHASE_ITEMS; n++) begin
            pick = $urandom_range(0, 9);
            c = ax + $urandom_range(0, 9);
            r = ay + $urandom_range(0, 9);
            if (c > 255) c = 255;
            if (r > 255) r = 255;
            if (pick == 9) begin
                // anywhere on the field range, in or out of the map
                c = $urandom_range(0, 255);
                r = $urandom_range(0, 255);
                pick = $urandom_range(0, 1) ? 0 : 5;
            end
            if (pick < 4)
                queue_op(ACT_WRITE, c, r,
                         $urandom_range(0, 1) ? quiet_cell()
                                              : CELL_W'($urandom_range(0, 255)));
            else
                queue_query(c, r);
        end
        settle();
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset registers: corners and value extremes, zero radius echoes stored value
        queue_op(ACT_WRITE, 0, 0, 8'sd127);
        queue_op(ACT_WRITE, 255, 255, -8'sd128);
        queue_op(ACT_WRITE, 255, 0, 8'sd0);
        queue_op(ACT_WRITE, 0, 255, 8'sd50);
        queue_query(0, 0);
        queue_query(255, 255);
        queue_query(255, 0);
        queue_query(0, 255);
        settle();

        // width beyond the limit clips, unit disc is the cell itself,
        // lowest threshold marks every cell occupied
        program_map(9'h1FF, 9'h100, 9'h1E1, 9'h080, 9'h07F);
        queue_query(255, 255);
        queue_query(0, 0);
        settle();

        // zero width, then zero height: everything is out of the map;
        // radius beyond the limit with nothing to read
        program_map(9'h000, 9'h100, 9'h01F, 9'h032, 9'h05A);
        queue_op(ACT_WRITE, 0, 0, 8'sd1);
        queue_query(255, 255);
        settle();
        program_map(9'h100, 9'h000, 9'h000, 9'h032, 9'h05A);
        queue_query(0, 0);
        settle();

        // tiny map under a full-size disc: clipping on both axes, writes past
        // the edge are refused, one occupied cell covers the whole map
        program_map(9'd5, 9'd3, 9'd16, 9'h17F, 9'h180);
        queue_query(2, 1);
        queue_op(ACT_WRITE, 5, 0, 8'sd127);
        queue_op(ACT_WRITE, 0, 3, 8'sd127);
        queue_query(0, 0);
        queue_op(ACT_WRITE, 4, 2, 8'sd127);
        queue_query(0, 0);
        queue_query(4, 2);
        queue_query(255, 255);
        settle();

        for (int p = 0; p < RAND_PHASES; p++)
            random_phase();

        // anything late or extra shows up in the monitor during the drain
        repeat (DRAIN) @(negedge i_clk);
        if (cell_results_due.size() != 0)
            report_mismatch("results never delivered", 0, cell_results_due.size());
        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // watchdog
    initial begin
        #10_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule

>>> occupancy_grid_disc_dilation.f
rtl/ogdd_pkg.sv
rtl/ogdd_dp.sv
rtl/ogdd_ctrl.sv
rtl/occupancy_grid_disc_dilation.sv
tb/tb_occupancy_grid_disc_dilation.sv
